// ===== rtl/dmtlo_pkg.sv =====
// Shared types and constants for the direct-mapped tag lookup with line ownership.
`default_nettype none

package dmtlo_pkg;

  localparam int unsigned TAG_W     = 24;
  localparam int unsigned CNT_OUT_W = 11;
  localparam int unsigned BSL_W     = 4;

  localparam logic [CNT_OUT_W-1:0] CNT_SAT   = 11'd2047;
  localparam logic [BSL_W-1:0]     BSL_RESET = 4'd7;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic             gpu;
  } line_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mem_rd;
    logic update;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic clr_last;
  } sts_t;

  typedef struct packed {
    logic                 hit;
    logic                 evicted;
    logic                 write_back;
    logic [TAG_W-1:0]     victim_tag;
    logic                 victim_was_gpu;
    logic                 owner_switched;
    logic                 wrote_dirty_line;
    logic [CNT_OUT_W-1:0] gpu_line_count;
    logic [CNT_OUT_W-1:0] gpu_dirty_count;
    logic [CNT_OUT_W-1:0] gpu_dirty_peak;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/dmtlo_req_if.sv =====
// Access channel: one word carries an address, a write flag and a requester flag.
`default_nettype none

interface dmtlo_req_if #(
  parameter int unsigned ADDR_BITS = 40
) ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] access_address;
  logic                 is_write;
  logic                 from_gpu;

  modport source (output valid, access_address, is_write, from_gpu, input ready);
  modport sink   (input valid, access_address, is_write, from_gpu, output ready);
endinterface

`default_nettype wire

// ===== rtl/dmtlo_rsp_if.sv =====
// Result channel: one word carries the lookup outcome and the ownership counts.
`default_nettype none

interface dmtlo_rsp_if
  import dmtlo_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 evicted;
  logic                 write_back;
  logic [TAG_W-1:0]     victim_tag;
  logic                 victim_was_gpu;
  logic                 owner_switched;
  logic                 wrote_dirty_line;
  logic [CNT_OUT_W-1:0] gpu_line_count;
  logic [CNT_OUT_W-1:0] gpu_dirty_count;
  logic [CNT_OUT_W-1:0] gpu_dirty_peak;

  modport source (
    output valid, hit, evicted, write_back, victim_tag, victim_was_gpu, owner_switched,
           wrote_dirty_line, gpu_line_count, gpu_dirty_count, gpu_dirty_peak,
    input  ready
  );
  modport sink (
    input  valid, hit, evicted, write_back, victim_tag, victim_was_gpu, owner_switched,
           wrote_dirty_line, gpu_line_count, gpu_dirty_count, gpu_dirty_peak,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/dmtlo_datapath.sv =====
// Datapath: set/tag split, line store, ownership counters and result register.
`default_nettype none

module dmtlo_datapath
  import dmtlo_pkg::*;
#(
  parameter int unsigned SETS      = 1024,
  parameter int unsigned ADDR_BITS = 40
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [BSL_W-1:0]     cfg_wdata_i,
  input  wire logic [ADDR_BITS-1:0] access_address_i,
  input  wire logic                 is_write_i,
  input  wire logic                 from_gpu_i,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  output rsp_t                      rsp_o
);

  localparam int unsigned IDX_W  = $clog2(SETS);
  localparam bit          POW2   = (SETS & (SETS - 1)) == 0;
  localparam int unsigned CNT_NW = $clog2(SETS + 1);
  localparam int unsigned CNT_W  = (CNT_NW > CNT_OUT_W) ? CNT_NW : CNT_OUT_W;

  logic [BSL_W-1:0]     bsl_q;
  logic [ADDR_BITS-1:0] shifted;
  logic                 wr_q, gpu_q;
  logic [IDX_W-1:0]     set_idx;
  logic [TAG_W-1:0]     tag;
  logic                 div_done;
  logic [IDX_W-1:0]     clr_idx_q;

  line_t                mem [SETS];
  line_t                rd_q;
  line_t                new_line, wdat;
  logic [IDX_W-1:0]     waddr;
  logic                 we;

  logic                 hit, og, ng, od, nd;
  logic [CNT_W-1:0]     lines_q, dirty_q, peak_q;
  logic [CNT_W-1:0]     lines_d, dirty_d, peak_d;
  rsp_t                 rsp_q, rsp_d;

  function automatic logic [CNT_OUT_W-1:0] sat(input logic [CNT_W-1:0] v);
    return (v > CNT_W'(CNT_SAT)) ? CNT_SAT : v[CNT_OUT_W-1:0];
  endfunction

  assign shifted = access_address_i >> bsl_q;

  generate
    if (POW2) begin : g_pow2
      logic [ADDR_BITS-1:0] wk_q, quo;
      assign quo      = wk_q >> IDX_W;
      assign set_idx  = wk_q[IDX_W-1:0];
      assign tag      = quo[TAG_W-1:0];
      assign div_done = 1'b1;

      always_ff @(posedge clk_i) begin
        if (cmd_i.load) begin
          wk_q <= shifted;
        end
      end
    end else begin : g_div
      localparam int unsigned DIG_W   = 8;
      localparam int unsigned NDIG    = (ADDR_BITS + DIG_W - 1) / DIG_W;
      localparam int unsigned NUM_W   = NDIG * DIG_W;
      localparam int unsigned STEP_W  = $clog2(NDIG + 1);
      localparam int unsigned V_W     = IDX_W + DIG_W;
      localparam int unsigned SH      = V_W + IDX_W;
      localparam logic [63:0] MAGIC64 = ((64'd1 << SH) + 64'(SETS) - 64'd1) / 64'(SETS);
      localparam logic [V_W:0]   MAGIC  = MAGIC64[V_W:0];
      localparam logic [V_W-1:0] SETS_V = V_W'(SETS);
      logic [NUM_W-1:0]  num_q, num_d;
      logic [IDX_W-1:0]  rem_q, rem_d;
      logic [TAG_W-1:0]  quo_q, quo_d;
      logic [V_W-1:0]    val, val_q, val_d, diff;
      logic [2*V_W:0]    prod;
      logic [DIG_W-1:0]  qd_q, qd_d;
      logic              ph_q, ph_d;
      logic [STEP_W-1:0] step_q, step_d;

      // Long division one byte at a time: a reciprocal multiply gives the quotient
      // digit, and the next step takes the digit times SETS off the partial value.
      assign val  = {rem_q, num_q[NUM_W-1 -: DIG_W]};
      assign prod = {{(V_W + 1){1'b0}}, val} * {{V_W{1'b0}}, MAGIC};
      assign diff = val_q - V_W'(qd_q) * SETS_V;

      always_comb begin
        num_d  = num_q;
        rem_d  = rem_q;
        quo_d  = quo_q;
        val_d  = val_q;
        qd_d   = qd_q;
        ph_d   = ph_q;
        step_d = step_q;
        if (cmd_i.load) begin
          num_d  = NUM_W'(shifted);
          rem_d  = '0;
          quo_d  = '0;
          ph_d   = 1'b0;
          step_d = '0;
        end else if (cmd_i.div_step) begin
          if (!ph_q) begin
            val_d = val;
            qd_d  = prod[SH +: DIG_W];
            ph_d  = 1'b1;
          end else begin
            rem_d  = diff[IDX_W-1:0];
            quo_d  = {quo_q[TAG_W-DIG_W-1:0], qd_q};
            num_d  = num_q << DIG_W;
            ph_d   = 1'b0;
            step_d = step_q + STEP_W'(1);
          end
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          step_q <= '0;
          ph_q   <= 1'b0;
        end else begin
          step_q <= step_d;
          ph_q   <= ph_d;
        end
      end

      always_ff @(posedge clk_i) begin
        num_q <= num_d;
        rem_q <= rem_d;
        quo_q <= quo_d;
        val_q <= val_d;
        qd_q  <= qd_d;
      end

      assign set_idx  = rem_q;
      assign tag      = quo_q;
      assign div_done = step_q == STEP_W'(NDIG);
    end
  endgenerate

  assign sts_o.div_done = div_done;
  assign sts_o.clr_last = clr_idx_q == IDX_W'(SETS - 1);

  assign hit = rd_q.valid && (rd_q.tag == tag);

  always_comb begin
    new_line.tag   = tag;
    new_line.valid = 1'b1;
    new_line.dirty = hit ? (rd_q.dirty | wr_q) : wr_q;
    new_line.gpu   = gpu_q;
  end

  assign og = rd_q.valid & rd_q.gpu;
  assign od = og & rd_q.dirty;
  assign ng = gpu_q;
  assign nd = gpu_q & new_line.dirty;

  assign lines_d = lines_q + CNT_W'(ng) - CNT_W'(og);
  assign dirty_d = dirty_q + CNT_W'(nd) - CNT_W'(od);
  assign peak_d  = (dirty_d > peak_q) ? dirty_d : peak_q;

  always_comb begin
    rsp_d.hit              = hit;
    rsp_d.evicted          = !hit && rd_q.valid;
    rsp_d.write_back       = !hit && rd_q.valid && rd_q.dirty;
    rsp_d.victim_tag       = (!hit && rd_q.valid) ? rd_q.tag : '0;
    rsp_d.victim_was_gpu   = !hit && og;
    rsp_d.owner_switched   = hit && (rd_q.gpu != gpu_q);
    rsp_d.wrote_dirty_line = hit && wr_q && rd_q.dirty;
    rsp_d.gpu_line_count   = sat(lines_d);
    rsp_d.gpu_dirty_count  = sat(dirty_d);
    rsp_d.gpu_dirty_peak   = sat(peak_d);
  end

  always_comb begin
    we    = cmd_i.clr_step | cmd_i.update;
    waddr = cmd_i.clr_step ? clr_idx_q : set_idx;
    wdat  = cmd_i.clr_step ? line_t'('0) : new_line;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      rd_q <= mem[set_idx];
    end
    if (we) begin
      mem[waddr] <= wdat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsl_q     <= BSL_RESET;
      clr_idx_q <= '0;
      lines_q   <= '0;
      dirty_q   <= '0;
      peak_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        bsl_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_step) begin
        clr_idx_q <= clr_idx_q + IDX_W'(1);
      end
      if (cmd_i.update) begin
        lines_q <= lines_d;
        dirty_q <= dirty_d;
        peak_q  <= peak_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      wr_q  <= is_write_i;
      gpu_q <= from_gpu_i;
    end
    if (cmd_i.update) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

  a_dirty_le_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dirty_q <= lines_q)
    else $error("GPU dirty line count exceeds GPU line count");

  a_peak_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= dirty_q)
    else $error("GPU dirty peak is below the current dirty count");

endmodule

`default_nettype wire

// ===== rtl/dmtlo_ctrl.sv =====
// Controller: clearing sweep, access sequencing and result valid flag.
`default_nettype none

module dmtlo_ctrl
  import dmtlo_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  wire logic rsp_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_UPD   = 2'd3;

  logic [1:0] st_q, st_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       slot_free;

  assign slot_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    st_d        = st_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (st_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          st_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.mem_rd = 1'b1;
          st_d         = ST_UPD;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_UPD: begin
        if (slot_free) begin
          cmd_o.update = 1'b1;
          st_d         = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    if (cmd_o.update) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      rsp_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  a_update_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> (!rsp_valid_q || rsp_ready_i))
    else $error("Result register overwritten before its word was taken");

  a_valid_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(st_q == ST_UPD))
    else $error("Result valid rose outside the update step");

endmodule

`default_nettype wire

// ===== rtl/direct_mapped_tag_lookup_owner_unit.sv =====
// Top level of the direct-mapped tag lookup with GPU/CPU line ownership.
//
//   Channel  Dir  Handshake        Word
//   req_i    in   valid/ready      access_address, is_write, from_gpu
//   rsp_o    out  valid/ready      hit, eviction, victim, ownership and counts
//   cfg      in   cfg_we_i         block_size_log2 in cfg_wdata_i
//
// When SETS is a power of two the set index and tag are taken directly from the
// shifted address; otherwise a byte-at-a-time remainder unit splits the block
// number, each byte in a multiply step and then a subtract step.
// After reset a clearing sweep zeroes every set with req_i.ready low.
// A new access is accepted while a result word waits; an access waits in its
// update step until the result register is free.
`default_nettype none

module direct_mapped_tag_lookup_owner_unit
  import dmtlo_pkg::*;
#(
  parameter int unsigned SETS      = 1024,
  parameter int unsigned ADDR_BITS = 40
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [BSL_W-1:0] cfg_wdata_i,
  dmtlo_req_if.sink             req_i,
  dmtlo_rsp_if.source           rsp_o
);

  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;

  dmtlo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dmtlo_datapath #(
    .SETS      (SETS),
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .access_address_i (req_i.access_address),
    .is_write_i       (req_i.is_write),
    .from_gpu_i       (req_i.from_gpu),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .rsp_o            (rsp)
  );

  assign rsp_o.hit              = rsp.hit;
  assign rsp_o.evicted          = rsp.evicted;
  assign rsp_o.write_back       = rsp.write_back;
  assign rsp_o.victim_tag       = rsp.victim_tag;
  assign rsp_o.victim_was_gpu   = rsp.victim_was_gpu;
  assign rsp_o.owner_switched   = rsp.owner_switched;
  assign rsp_o.wrote_dirty_line = rsp.wrote_dirty_line;
  assign rsp_o.gpu_line_count   = rsp.gpu_line_count;
  assign rsp_o.gpu_dirty_count  = rsp.gpu_dirty_count;
  assign rsp_o.gpu_dirty_peak   = rsp.gpu_dirty_peak;

endmodule

`default_nettype wire
